[rtl/psfp_pkg.sv]
`timescale 1ns / 1ps
// Package for the particle sensor frame parser.
// Frame constants, status codes and the result struct. No dependencies.
package psfp_pkg;

    localparam logic [7:0] HDR_LEAD   = 8'h16;
    localparam logic [7:0] HDR1_BASIC = 8'h11;
    localparam logic [7:0] HDR2_BASIC = 8'h0B;
    localparam logic [7:0] HDR1_K     = 8'h0D;
    localparam logic [7:0] HDR2_K     = 8'h02;

    localparam int POS_W         = 5;
    localparam int HDR_LEN       = 3;
    localparam int PAYLOAD_BASIC = 16;
    localparam int PAYLOAD_K     = 12;
    localparam int OFS_PM2_5     = 5;
    localparam int OFS_PM1_0     = 9;
    localparam int OFS_PM10      = 13;

    localparam logic [POS_W-1:0] SUM_POS_BASIC = POS_W'(HDR_LEN + PAYLOAD_BASIC);
    localparam logic [POS_W-1:0] SUM_POS_K     = POS_W'(HDR_LEN + PAYLOAD_K);

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_HEADER = 2'd1,
        ST_SUM    = 2'd2
    } t_status;

    typedef struct packed {
        t_status     frame_status;
        logic [15:0] pm1_0_value;
        logic [15:0] pm2_5_value;
        logic [15:0] pm10_value;
    } t_result;

endpackage

[rtl/psfp_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frame parser: byte input and result output.
// No dependencies.
interface psfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [15:0] pm1_0_value;
    logic [15:0] pm2_5_value;
    logic [15:0] pm10_value;

    modport source (output valid, output frame_status, output pm1_0_value,
                    output pm2_5_value, output pm10_value, input ready);
    modport sink   (input valid, input frame_status, input pm1_0_value,
                    input pm2_5_value, input pm10_value, output ready);
endinterface

[rtl/psfp_frame_fsm.sv]
`timescale 1ns / 1ps
// Frame tracker: byte position, running sum and captured readings.
// Uses psfp_pkg.
module psfp_frame_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_model,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_emit,
    output psfp_pkg::t_result o_result
);

    logic [psfp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_sum, n_sum;
    logic [15:0]                r_pm1_0, n_pm1_0;
    logic [15:0]                r_pm2_5, n_pm2_5;
    logic [15:0]                r_pm10, n_pm10;

    logic [psfp_pkg::POS_W-1:0] sum_pos;
    logic [7:0]                 sum;
    logic [7:0]                 want;

    always_comb begin
        sum_pos = i_model ? psfp_pkg::SUM_POS_K : psfp_pkg::SUM_POS_BASIC;
        sum     = ((r_pos == '0) ? 8'd0 : r_sum) + i_byte;
        unique case (r_pos)
            psfp_pkg::POS_W'(0): want = psfp_pkg::HDR_LEAD;
            psfp_pkg::POS_W'(1): want = i_model ? psfp_pkg::HDR1_K : psfp_pkg::HDR1_BASIC;
            default:             want = i_model ? psfp_pkg::HDR2_K : psfp_pkg::HDR2_BASIC;
        endcase

        n_pos   = r_pos + 1'b1;
        n_sum   = sum;
        n_pm1_0 = r_pm1_0;
        n_pm2_5 = r_pm2_5;
        n_pm10  = r_pm10;
        o_emit  = 1'b0;
        o_result.frame_status = psfp_pkg::ST_HEADER;
        o_result.pm1_0_value  = '0;
        o_result.pm2_5_value  = '0;
        o_result.pm10_value   = '0;

        if (r_pos < psfp_pkg::POS_W'(psfp_pkg::HDR_LEN)) begin
            if (i_byte != want) begin
                n_pos  = '0;
                n_sum  = '0;
                o_emit = 1'b1;
            end
        end else if (r_pos < sum_pos) begin
            // readings are big-endian, high byte first
            if (r_pos == psfp_pkg::POS_W'(psfp_pkg::OFS_PM2_5))     n_pm2_5[15:8] = i_byte;
            if (r_pos == psfp_pkg::POS_W'(psfp_pkg::OFS_PM2_5 + 1)) n_pm2_5[7:0]  = i_byte;
            if (r_pos == psfp_pkg::POS_W'(psfp_pkg::OFS_PM1_0))     n_pm1_0[15:8] = i_byte;
            if (r_pos == psfp_pkg::POS_W'(psfp_pkg::OFS_PM1_0 + 1)) n_pm1_0[7:0]  = i_byte;
            if (r_pos == psfp_pkg::POS_W'(psfp_pkg::OFS_PM10))      n_pm10[15:8]  = i_byte;
            if (r_pos == psfp_pkg::POS_W'(psfp_pkg::OFS_PM10 + 1))  n_pm10[7:0]   = i_byte;
        end else begin
            n_pos  = '0;
            n_sum  = '0;
            o_emit = 1'b1;
            if (r_pos == sum_pos) begin
                if (sum != 8'd0) begin
                    o_result.frame_status = psfp_pkg::ST_SUM;
                end else begin
                    o_result.frame_status = psfp_pkg::ST_GOOD;
                    o_result.pm1_0_value  = r_pm1_0;
                    o_result.pm2_5_value  = r_pm2_5;
                    o_result.pm10_value   = r_pm10;
                end
            end
            // past the checksum offset (model changed mid-frame): header error
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_pm1_0 <= '0;
            r_pm2_5 <= '0;
            r_pm10  <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_pm1_0 <= n_pm1_0;
            r_pm2_5 <= n_pm2_5;
            r_pm10  <= n_pm10;
        end
    end

endmodule

[rtl/psfp_out_reg.sv]
`timescale 1ns / 1ps
// Result register holding one result beat until the sink takes it.
// Uses psfp_pkg.
module psfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  psfp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output psfp_pkg::t_result o_result
);

    logic              r_valid;
    psfp_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/particle_sensor_frame_parser_core.sv]
`timescale 1ns / 1ps
// Particle sensor response frame parser, top level.
// Uses psfp_pkg, psfp_ifs (channels), psfp_frame_fsm and psfp_out_reg.

// Takes one received serial byte per beat and reports one result beat each
// time a response frame completes (good or bad checksum) or a byte breaks
// the header. Throughput is one byte per clock while the result side does not
// stall; an accepted byte sits in the input register, then passes through
// the frame tracker into the result register. The input register advances
// whenever the result register is empty or being drained; while a result
// waits unread, one more byte is held in the input register and then the
// input stalls. i_cfg_we/i_cfg_data select the sensor model
// (0 = basic, 20-byte frame; 1 = K, 16-byte frame) and should be written only
// while no byte is in flight.
module particle_sensor_frame_parser_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    psfp_byte_if.sink      i_byte,
    psfp_result_if.source  o_result
);

    // config register
    logic r_sensor_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_model <= 1'b0;
        end else if (i_cfg_we) begin
            r_sensor_model <= i_cfg_data;
        end
    end

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_valid;
    logic       out_free;
    logic       step;
    logic       emit;

    psfp_pkg::t_result fsm_result;
    psfp_pkg::t_result out_result;

    assign out_free     = !out_valid || o_result.ready;
    assign step         = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.rx_byte;
        end
    end

    // frame tracking and result formation
    psfp_frame_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_model  (r_sensor_model),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (fsm_result)
    );

    // result register
    psfp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && emit),
        .i_result (fsm_result),
        .i_ready  (o_result.ready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_result.valid        = out_valid;
    assign o_result.frame_status = out_result.frame_status;
    assign o_result.pm1_0_value  = out_result.pm1_0_value;
    assign o_result.pm2_5_value  = out_result.pm2_5_value;
    assign o_result.pm10_value   = out_result.pm10_value;

`ifndef SYNTHESIS
    // a byte held in the input register stays put while the result side is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_byte))
        else $error("input register changed while stalled");

    // rejected frames carry zero readings
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.frame_status != psfp_pkg::ST_GOOD) |->
        (o_result.pm1_0_value == 16'd0) && (o_result.pm2_5_value == 16'd0) &&
        (o_result.pm10_value == 16'd0))
        else $error("rejected frame with nonzero readings");

    // status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.frame_status != 2'd3))
        else $error("undefined frame status");
`endif

endmodule
